>>> src/ortest_pkg.sv
// shared constants, codes and the arctangent table for the overlap test
`default_nettype none
package ortest_pkg;

  // trig values are Q28 in a 32-bit signed word, angles are 32-bit turns
  localparam int TRIG_W    = 32;
  localparam int TRIG_FRAC = 28;
  localparam int ANG_W     = 32;
  localparam int ATAN_N    = 24;
  localparam logic signed [TRIG_W-1:0] TRIG_GAIN_START = 32'sd163008219;

  localparam int AXIS_W = 3;
  localparam logic [AXIS_W-1:0] AXIS_FIRST_WIDTH   = 3'd0;
  localparam logic [AXIS_W-1:0] AXIS_FIRST_HEIGHT  = 3'd1;
  localparam logic [AXIS_W-1:0] AXIS_SECOND_WIDTH  = 3'd2;
  localparam logic [AXIS_W-1:0] AXIS_SECOND_HEIGHT = 3'd3;
  localparam logic [AXIS_W-1:0] AXIS_NONE          = 3'd4;

  function automatic logic signed [ANG_W-1:0] atan_turn(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/ortest_if.sv
// valid/ready channel interfaces for rectangle pairs and overlap results
`default_nettype none
interface ortest_in_if #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_center_x;
  logic signed [COORD_WIDTH-1:0] first_center_y;
  logic signed [COORD_WIDTH-1:0] first_width;
  logic signed [COORD_WIDTH-1:0] first_height;
  logic        [ANGLE_WIDTH-1:0] first_angle;
  logic signed [COORD_WIDTH-1:0] second_center_x;
  logic signed [COORD_WIDTH-1:0] second_center_y;
  logic signed [COORD_WIDTH-1:0] second_width;
  logic signed [COORD_WIDTH-1:0] second_height;
  logic        [ANGLE_WIDTH-1:0] second_angle;

  modport source (output valid, first_center_x, first_center_y, first_width, first_height,
                  first_angle, second_center_x, second_center_y, second_width,
                  second_height, second_angle, input ready);
  modport sink (input valid, first_center_x, first_center_y, first_width, first_height,
                first_angle, second_center_x, second_center_y, second_width,
                second_height, second_angle, output ready);
endinterface

interface ortest_out_if;
  logic       valid;
  logic       ready;
  logic       overlapping;
  logic [2:0] separating_axis;

  modport source (output valid, overlapping, separating_axis, input ready);
  modport sink (input valid, overlapping, separating_axis, output ready);
endinterface
`default_nettype wire

>>> src/ortest_cordic.sv
// pipelined rotation-mode cordic, one iteration per stage, then quadrant fix-up
`default_nettype none
module ortest_cordic #(
  parameter int ITERS = 16
) (
  input  wire logic                                clk,
  input  wire logic [ITERS:0]                      en,
  input  wire logic [ortest_pkg::ANG_W-1:0]        angle,
  output logic signed [ortest_pkg::TRIG_W-1:0]     cos_o,
  output logic signed [ortest_pkg::TRIG_W-1:0]     sin_o
);
  import ortest_pkg::*;

  logic signed [TRIG_W-1:0] x_r [ITERS];
  logic signed [TRIG_W-1:0] y_r [ITERS];
  logic signed [ANG_W-1:0]  z_r [ITERS];
  logic [1:0]               q_r [ITERS];
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  logic [ANG_W-1:0] biased;
  logic [1:0]       quad;
  logic signed [ANG_W-1:0] resid;

  // nearest quarter turn and signed residue
  always_comb begin
    biased = angle + ANG_W'(32'h2000_0000);
    quad   = biased[ANG_W-1 -: 2];
    resid  = signed'(angle - {quad, {(ANG_W-2){1'b0}}});
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    logic signed [TRIG_W-1:0] xi, yi, xs, ys, x_nxt, y_nxt;
    logic signed [ANG_W-1:0]  zi, z_nxt;
    logic [1:0]               qi;
    if (i == 0) begin : g_first
      assign xi = TRIG_GAIN_START;
      assign yi = '0;
      assign zi = resid;
      assign qi = quad;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = q_r[i-1];
    end
    always_comb begin
      xs = xi >>> i;
      ys = yi >>> i;
      if (!zi[ANG_W-1]) begin
        x_nxt = xi - ys;
        y_nxt = yi + xs;
        z_nxt = zi - atan_turn(i);
      end else begin
        x_nxt = xi + ys;
        y_nxt = yi - xs;
        z_nxt = zi + atan_turn(i);
      end
    end
    always_ff @(posedge clk) begin
      if (en[i]) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        q_r[i] <= qi;
      end
    end
  end

  logic signed [TRIG_W-1:0] cos_nxt, sin_nxt;
  always_comb begin
    case (q_r[ITERS-1])
      2'd0: begin
        cos_nxt = x_r[ITERS-1];
        sin_nxt = y_r[ITERS-1];
      end
      2'd1: begin
        cos_nxt = -y_r[ITERS-1];
        sin_nxt = x_r[ITERS-1];
      end
      2'd2: begin
        cos_nxt = -x_r[ITERS-1];
        sin_nxt = -y_r[ITERS-1];
      end
      default: begin
        cos_nxt = y_r[ITERS-1];
        sin_nxt = -x_r[ITERS-1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[ITERS]) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;
endmodule
`default_nettype wire

>>> src/ortest_proj.sv
// projection products, axis sums and the four separation compares
`default_nettype none
module ortest_proj #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                                  clk,
  input  wire logic [2:0]                            en,
  input  wire logic signed [COORD_WIDTH:0]           dx,
  input  wire logic signed [COORD_WIDTH:0]           dy,
  input  wire logic [COORD_WIDTH-1:0]                w0,
  input  wire logic [COORD_WIDTH-1:0]                h0,
  input  wire logic [COORD_WIDTH-1:0]                w1,
  input  wire logic [COORD_WIDTH-1:0]                h1,
  input  wire logic signed [ortest_pkg::TRIG_W-1:0]  c0,
  input  wire logic signed [ortest_pkg::TRIG_W-1:0]  s0,
  input  wire logic signed [ortest_pkg::TRIG_W-1:0]  c1,
  input  wire logic signed [ortest_pkg::TRIG_W-1:0]  s1,
  input  wire logic signed [ortest_pkg::TRIG_W-1:0]  cd,
  input  wire logic signed [ortest_pkg::TRIG_W-1:0]  sd,
  output logic                                       overlapping,
  output logic [ortest_pkg::AXIS_W-1:0]              separating_axis
);
  import ortest_pkg::*;

  localparam int PW  = COORD_WIDTH + 1 + TRIG_W;   // signed offset products
  localparam int UW  = COORD_WIDTH + TRIG_W;       // unsigned extent products
  localparam int CMP = PW + 2;

  // stage 1: products
  logic [TRIG_W-1:0] cdm, sdm;
  assign cdm = cd[TRIG_W-1] ? TRIG_W'(-cd) : TRIG_W'(cd);
  assign sdm = sd[TRIG_W-1] ? TRIG_W'(-sd) : TRIG_W'(sd);

  logic signed [PW-1:0] p_r [8];
  logic [UW-1:0]        u_r [8];
  logic [COORD_WIDTH-1:0] w0_r, h0_r, w1_r, h1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r[0] <= PW'(dx) * PW'(c0);
      p_r[1] <= PW'(dy) * PW'(s0);
      p_r[2] <= PW'(dy) * PW'(c0);
      p_r[3] <= PW'(dx) * PW'(s0);
      p_r[4] <= PW'(dx) * PW'(c1);
      p_r[5] <= PW'(dy) * PW'(s1);
      p_r[6] <= PW'(dy) * PW'(c1);
      p_r[7] <= PW'(dx) * PW'(s1);
      u_r[0] <= UW'(w1) * UW'(cdm);
      u_r[1] <= UW'(h1) * UW'(sdm);
      u_r[2] <= UW'(w1) * UW'(sdm);
      u_r[3] <= UW'(h1) * UW'(cdm);
      u_r[4] <= UW'(w0) * UW'(cdm);
      u_r[5] <= UW'(h0) * UW'(sdm);
      u_r[6] <= UW'(w0) * UW'(sdm);
      u_r[7] <= UW'(h0) * UW'(cdm);
      w0_r <= w0;
      h0_r <= h0;
      w1_r <= w1;
      h1_r <= h1;
    end
  end

  // stage 2: projected offsets and summed extents
  logic signed [PW:0] t_sum [4];
  logic [CMP-1:0]     tl_nxt [4], lim_nxt [4];
  logic [CMP-1:0]     tl_r [4], lim_r [4];

  always_comb begin
    t_sum[0] = (PW+1)'(p_r[0]) + (PW+1)'(p_r[1]);
    t_sum[1] = (PW+1)'(p_r[2]) - (PW+1)'(p_r[3]);
    t_sum[2] = (PW+1)'(p_r[4]) + (PW+1)'(p_r[5]);
    t_sum[3] = (PW+1)'(p_r[6]) - (PW+1)'(p_r[7]);
    for (int k = 0; k < 4; k++) begin
      // doubled magnitude stands in for halved extents
      tl_nxt[k] = t_sum[k][PW] ? {CMP'(-t_sum[k])} << 1 : {CMP'(t_sum[k])} << 1;
    end
    lim_nxt[0] = CMP'({w0_r, {TRIG_FRAC{1'b0}}}) + CMP'(u_r[0]) + CMP'(u_r[1]);
    lim_nxt[1] = CMP'({h0_r, {TRIG_FRAC{1'b0}}}) + CMP'(u_r[2]) + CMP'(u_r[3]);
    lim_nxt[2] = CMP'({w1_r, {TRIG_FRAC{1'b0}}}) + CMP'(u_r[4]) + CMP'(u_r[5]);
    lim_nxt[3] = CMP'({h1_r, {TRIG_FRAC{1'b0}}}) + CMP'(u_r[6]) + CMP'(u_r[7]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tl_r  <= tl_nxt;
      lim_r <= lim_nxt;
    end
  end

  // stage 3: first separating axis wins
  logic [3:0]         sep;
  logic [AXIS_W-1:0]  axis_nxt;
  logic               ovl_r;
  logic [AXIS_W-1:0]  axis_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sep[k] = tl_r[k] > lim_r[k];
    end
    if (sep[0])      axis_nxt = AXIS_FIRST_WIDTH;
    else if (sep[1]) axis_nxt = AXIS_FIRST_HEIGHT;
    else if (sep[2]) axis_nxt = AXIS_SECOND_WIDTH;
    else if (sep[3]) axis_nxt = AXIS_SECOND_HEIGHT;
    else             axis_nxt = AXIS_NONE;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ovl_r  <= ~|sep;
      axis_r <= axis_nxt;
    end
  end

  assign overlapping     = ovl_r;
  assign separating_axis = axis_r;
endmodule
`default_nettype wire

>>> src/oriented_rect_overlap_test.sv
// top level: oriented rectangle overlap test by separating axes
//
//   channel  dir  beat contents
//   in_ch    in   two rectangles: centers, sizes, binary angles
//   out_ch   out  overlapping flag and first separating axis
//
// one beat enters per cycle while in_ch.ready is high; the stages are
// the input register, one cordic stage per iteration, quadrant fix-up,
// multiply, sum and compare. rst_n clears only the stage valid bits.
// a stall at out_ch only holds stages that are full; empty stages
// keep filling, so in_ch.ready drops only when the whole pipe is full
`default_nettype none
module oriented_rect_overlap_test #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_WIDTH     = 16,
  parameter int TRIG_ITERATIONS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ortest_in_if.sink  in_ch,
  ortest_out_if.source out_ch
);
  import ortest_pkg::*;

  localparam int N     = TRIG_ITERATIONS;
  localparam int DEPTH = N + 5;

  logic [DEPTH-1:0] v_r;
  logic [DEPTH:0]   en;

  always_comb begin
    en[DEPTH] = out_ch.ready;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = en[0];

  // input stage: offsets, size magnitudes, angles widened to a full turn
  logic signed [COORD_WIDTH:0]  dx_r, dy_r;
  logic [COORD_WIDTH-1:0]       w0_r, h0_r, w1_r, h1_r;
  logic [ANG_W-1:0]             a0_r, a1_r, ad_r;
  logic [ANGLE_WIDTH-1:0]       adiff;

  assign adiff = in_ch.second_angle - in_ch.first_angle;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= (COORD_WIDTH+1)'(in_ch.second_center_x) - (COORD_WIDTH+1)'(in_ch.first_center_x);
      dy_r <= (COORD_WIDTH+1)'(in_ch.second_center_y) - (COORD_WIDTH+1)'(in_ch.first_center_y);
      w0_r <= in_ch.first_width[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.first_width)
                                               : COORD_WIDTH'(in_ch.first_width);
      h0_r <= in_ch.first_height[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.first_height)
                                                : COORD_WIDTH'(in_ch.first_height);
      w1_r <= in_ch.second_width[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.second_width)
                                                : COORD_WIDTH'(in_ch.second_width);
      h1_r <= in_ch.second_height[COORD_WIDTH-1] ? COORD_WIDTH'(-in_ch.second_height)
                                                 : COORD_WIDTH'(in_ch.second_height);
      a0_r <= {in_ch.first_angle, {(ANG_W-ANGLE_WIDTH){1'b0}}};
      a1_r <= {in_ch.second_angle, {(ANG_W-ANGLE_WIDTH){1'b0}}};
      ad_r <= {adiff, {(ANG_W-ANGLE_WIDTH){1'b0}}};
    end
  end

  logic signed [TRIG_W-1:0] c0, s0, c1, s1, cd, sd;

  ortest_cordic #(.ITERS(N)) u_trig0 (
    .clk(clk), .en(en[N+1:1]), .angle(a0_r), .cos_o(c0), .sin_o(s0)
  );
  ortest_cordic #(.ITERS(N)) u_trig1 (
    .clk(clk), .en(en[N+1:1]), .angle(a1_r), .cos_o(c1), .sin_o(s1)
  );
  ortest_cordic #(.ITERS(N)) u_trigd (
    .clk(clk), .en(en[N+1:1]), .angle(ad_r), .cos_o(cd), .sin_o(sd)
  );

  // geometry rides alongside the cordic stages
  logic signed [COORD_WIDTH:0] dx_d [N+1];
  logic signed [COORD_WIDTH:0] dy_d [N+1];
  logic [COORD_WIDTH-1:0]      w0_d [N+1];
  logic [COORD_WIDTH-1:0]      h0_d [N+1];
  logic [COORD_WIDTH-1:0]      w1_d [N+1];
  logic [COORD_WIDTH-1:0]      h1_d [N+1];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx_d[0] <= dx_r;
      dy_d[0] <= dy_r;
      w0_d[0] <= w0_r;
      h0_d[0] <= h0_r;
      w1_d[0] <= w1_r;
      h1_d[0] <= h1_r;
    end
    for (int j = 1; j <= N; j++) begin
      if (en[j+1]) begin
        dx_d[j] <= dx_d[j-1];
        dy_d[j] <= dy_d[j-1];
        w0_d[j] <= w0_d[j-1];
        h0_d[j] <= h0_d[j-1];
        w1_d[j] <= w1_d[j-1];
        h1_d[j] <= h1_d[j-1];
      end
    end
  end

  ortest_proj #(.COORD_WIDTH(COORD_WIDTH)) u_proj (
    .clk(clk), .en(en[N+4:N+2]),
    .dx(dx_d[N]), .dy(dy_d[N]),
    .w0(w0_d[N]), .h0(h0_d[N]), .w1(w1_d[N]), .h1(h1_d[N]),
    .c0(c0), .s0(s0), .c1(c1), .s1(s1), .cd(cd), .sd(sd),
    .overlapping(out_ch.overlapping), .separating_axis(out_ch.separating_axis)
  );

  assign out_ch.valid = v_r[DEPTH-1];
endmodule
`default_nettype wire

>>> src/ortest_checker.sv
// port-level checks for the overlap test, bound to the top level
`default_nettype none
module ortest_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_overlapping,
  input wire logic [2:0] out_separating_axis
);
  import ortest_pkg::*;

  // a draining output never backs up the input
  a_ready_through: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped under stall");

  a_flag_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_overlapping == (out_separating_axis == AXIS_NONE)))
    else $error("overlap flag disagrees with axis");

  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_separating_axis <= AXIS_NONE))
    else $error("axis code out of range");
endmodule

bind oriented_rect_overlap_test ortest_checker u_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_overlapping(out_ch.overlapping),
  .out_separating_axis(out_ch.separating_axis)
);
`default_nettype wire
